@@ rtl/flm_pkg.sv @@
// fixed-string line matcher: shared constants, types and register indexes
// no dependencies; taken in by every other file of the block
`timescale 1ns / 1ps
`default_nettype none

package flm_pkg;

   localparam int PATTERN_MAX       = 32;
   localparam int LENGTH_BITS       = 16;
   localparam int PATTERN_REG_BYTES = 32;
   localparam int WORD_BYTES        = 8;

   localparam int TEXT_BYTE_BITS    = 8;
   localparam int LINE_LENGTH_BITS  = 16;
   localparam int PATTERN_LEN_BITS  = 6;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 64;

   localparam int COUNT_BITS    = (LENGTH_BITS < LINE_LENGTH_BITS) ? LENGTH_BITS
                                                                   : LINE_LENGTH_BITS;
   localparam int CELL_IDX_BITS = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   localparam logic [TEXT_BYTE_BITS-1:0] NEWLINE = TEXT_BYTE_BITS'(10);

   typedef logic [TEXT_BYTE_BITS-1:0] text_byte_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LENGTH = 3'd0,
      CSR_PATTERN_WORD_0 = 3'd1,
      CSR_PATTERN_WORD_1 = 3'd2,
      CSR_PATTERN_WORD_2 = 3'd3,
      CSR_PATTERN_WORD_3 = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [PATTERN_LEN_BITS-1:0]              length;
      logic [PATTERN_MAX-1:0][TEXT_BYTE_BITS-1:0] bytes;
   } pattern_cfg_type;

endpackage : flm_pkg

`default_nettype wire

@@ rtl/flm_channels.sv @@
// fixed-string line matcher: request, response and register write channels
// depends on flm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface flm_req_if;
   import flm_pkg::*;
   logic          valid;
   logic          ready;
   text_byte_type text_byte;
   logic          end_of_input;
   modport source (output valid, text_byte, end_of_input, input ready);
   modport sink   (input valid, text_byte, end_of_input, output ready);
endinterface : flm_req_if

interface flm_rsp_if;
   import flm_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        line_matched;
   logic [LINE_LENGTH_BITS-1:0] line_length;
   modport source (output valid, line_matched, line_length, input ready);
   modport sink   (input valid, line_matched, line_length, output ready);
endinterface : flm_rsp_if

interface flm_csr_if;
   import flm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface : flm_csr_if

`default_nettype wire

@@ rtl/flm_csr_regs.sv @@
// fixed-string line matcher: pattern length and pattern byte registers
// depends on flm_pkg and flm_csr_if
`timescale 1ns / 1ps
`default_nettype none

module flm_csr_regs
   import flm_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   flm_csr_if.sink        csr_if,
   output pattern_cfg_type pattern_cfg
);

   logic [PATTERN_LEN_BITS-1:0]                 length_ff;
   logic [PATTERN_LEN_BITS-1:0]                 length_in;
   logic [PATTERN_MAX-1:0][TEXT_BYTE_BITS-1:0]  bytes_ff;
   logic [PATTERN_MAX-1:0][TEXT_BYTE_BITS-1:0]  bytes_in;
   logic                                        write;

   assign csr_if.ready = 1'b1;
   assign write        = csr_if.valid;

   always_comb begin
      length_in = length_ff;
      bytes_in  = bytes_ff;
      if (write && (csr_if.index == CSR_PATTERN_LENGTH)) begin
         length_in = csr_if.data[PATTERN_LEN_BITS-1:0];
      end
      for (int pos = 0; pos < PATTERN_MAX; pos++) begin
         if (pos < PATTERN_REG_BYTES) begin
            if (write && (csr_if.index ==
                          CSR_INDEX_BITS'(int'(CSR_PATTERN_WORD_0) + pos / WORD_BYTES))) begin
               bytes_in[pos] = csr_if.data[TEXT_BYTE_BITS*(pos % WORD_BYTES) +: TEXT_BYTE_BITS];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= PATTERN_LEN_BITS'(1);
         bytes_ff  <= '0;
      end else begin
         length_ff <= length_in;
         bytes_ff  <= bytes_in;
      end
   end

   // lengths beyond the cell row use the whole row
   always_comb begin
      pattern_cfg.bytes = bytes_ff;
      if (int'(length_ff) > PATTERN_MAX) begin
         pattern_cfg.length = PATTERN_LEN_BITS'(PATTERN_MAX);
      end else begin
         pattern_cfg.length = length_ff;
      end
   end

endmodule : flm_csr_regs

`default_nettype wire

@@ rtl/flm_cell.sv @@
// fixed-string line matcher: one cell of the matching row
// holds one partial-match bit; depends on flm_pkg
`timescale 1ns / 1ps
`default_nettype none

module flm_cell
   import flm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          advance,
   input  wire logic          clear,
   input  wire text_byte_type text_byte,
   input  wire text_byte_type pattern_byte,
   input  wire logic          prev_match,
   output logic               match_now,
   output logic               match_held
);

   logic match_ff;
   logic match_in;

   // prefix up to this cell ends at the incoming byte
   assign match_now  = prev_match && (text_byte == pattern_byte);
   assign match_held = match_ff;

   always_comb begin
      match_in = match_ff;
      if (advance) begin
         match_in = clear ? 1'b0 : match_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

endmodule : flm_cell

`default_nettype wire

@@ rtl/fixed_string_line_matcher.sv @@
// fixed-string line matcher: top level, cell row, line counter, result register
// depends on flm_pkg, flm_channels, flm_csr_regs and flm_cell
//
//   channel  | direction | payload                         | moves on
//   req_if   | in        | text_byte, end_of_input         | valid && ready
//   rsp_if   | out       | line_matched, line_length       | valid && ready
//   csr_if   | in        | index, data                     | valid && ready (ready always high)
//
// one text byte a cycle while ready is high; each byte steps the whole row of cells at once
// a line result appears in the cycle after its closing request is taken
// request ready drops only while a result waits and the response side stalls
// synchronous reset clears match bits, line state, pattern bytes; pattern length goes to one
`timescale 1ns / 1ps
`default_nettype none

module fixed_string_line_matcher
   import flm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   flm_req_if.sink   req_if,
   flm_rsp_if.source rsp_if,
   flm_csr_if.sink   csr_if
);

   pattern_cfg_type          pattern_cfg;
   logic [PATTERN_MAX-1:0]   match_now;
   logic [PATTERN_MAX-1:0]   match_held;
   logic                     req_fire;
   logic                     line_end;
   logic                     hit_now;
   logic [CELL_IDX_BITS-1:0] last_cell;

   logic                        line_hit_ff;
   logic                        line_hit_in;
   logic [COUNT_BITS-1:0]       count_ff;
   logic [COUNT_BITS-1:0]       count_in;
   logic [COUNT_BITS-1:0]       count_next;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_matched_ff;
   logic                        rsp_matched_in;
   logic [LINE_LENGTH_BITS-1:0] rsp_length_ff;
   logic [LINE_LENGTH_BITS-1:0] rsp_length_in;

   flm_csr_regs u_csr_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_if      (csr_if),
      .pattern_cfg (pattern_cfg)
   );

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;
   assign line_end     = (req_if.text_byte == NEWLINE) || req_if.end_of_input;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      flm_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (req_fire),
         .clear        (line_end),
         .text_byte    (req_if.text_byte),
         .pattern_byte (pattern_cfg.bytes[k]),
         .prev_match   ((k == 0) ? 1'b1 : match_held[(k == 0) ? 0 : k - 1]),
         .match_now    (match_now[k]),
         .match_held   (match_held[k])
      );
   end

   // empty pattern matches every line
   assign last_cell = CELL_IDX_BITS'(pattern_cfg.length - PATTERN_LEN_BITS'(1));
   assign hit_now   = (pattern_cfg.length == '0) || match_now[last_cell];

   assign count_next = (count_ff == '1) ? count_ff : count_ff + COUNT_BITS'(1);

   always_comb begin
      line_hit_in    = line_hit_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_matched_in = rsp_matched_ff;
      rsp_length_in  = rsp_length_ff;
      if (req_fire) begin
         if (line_end) begin
            line_hit_in    = 1'b0;
            count_in       = '0;
            rsp_valid_in   = 1'b1;
            rsp_matched_in = line_hit_ff || hit_now;
            rsp_length_in  = LINE_LENGTH_BITS'(count_next);
         end else begin
            line_hit_in = line_hit_ff || hit_now;
            count_in    = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_hit_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         line_hit_ff  <= line_hit_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_matched_ff <= rsp_matched_in;
      rsp_length_ff  <= rsp_length_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.line_matched = rsp_matched_ff;
   assign rsp_if.line_length  = rsp_length_ff;

endmodule : fixed_string_line_matcher

`default_nettype wire

@@ test/flm_line_checker.sv @@
// line checker for the fixed-string line matcher: follows register writes and text
// requests, predicts each line result and compares it with the response channel
// depends on flm_pkg and flm_channels
`timescale 1ns / 1ps

module flm_line_checker
   import flm_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   flm_req_if          req_if,
   flm_rsp_if          rsp_if,
   flm_csr_if          csr_if,
   output int unsigned mismatches,
   output int unsigned lines_waiting
);

   localparam int LINE_LIMIT = (LENGTH_BITS >= 16) ? 65535 : (1 << LENGTH_BITS) - 1;

   typedef struct packed {
      logic                        matched;
      logic [LINE_LENGTH_BITS-1:0] length;
   } line_result_type;

   logic [PATTERN_LEN_BITS-1:0] pattern_len;
   text_byte_type               pattern [PATTERN_MAX];
   text_byte_type               history [PATTERN_MAX];
   int unsigned                 window_fill;
   logic                        hit;
   int unsigned                 byte_count;
   line_result_type             expected_lines [$];

   initial mismatches = 0;

   function automatic void apply_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                          input logic [CSR_DATA_BITS-1:0] value);
      int base;
      if (idx == CSR_PATTERN_LENGTH) begin
         pattern_len = value[PATTERN_LEN_BITS-1:0];
         return;
      end
      if (idx > CSR_PATTERN_WORD_3) return;
      base = (int'(idx) - int'(CSR_PATTERN_WORD_0)) * WORD_BYTES;
      for (int b = 0; b < WORD_BYTES; b++)
         if (base + b < PATTERN_MAX) pattern[base + b] = value[8*b +: 8];
   endfunction

   // shifts one byte into the line window; returns 1 when the line closes
   function automatic bit scan_byte(input text_byte_type b, input logic last,
                                    output line_result_type done);
      int unsigned span;
      bit          seen;
      for (int i = PATTERN_MAX - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = b;
      if (window_fill < PATTERN_MAX) window_fill++;
      if (byte_count < LINE_LIMIT) byte_count++;
      span = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : pattern_len;
      seen = (window_fill >= span);
      for (int k = 0; k < int'(span); k++)
         if (history[int'(span) - 1 - k] != pattern[k]) seen = 1'b0;
      if (seen) hit = 1'b1;
      done.matched = hit;
      done.length  = LINE_LENGTH_BITS'(byte_count);
      if (b == NEWLINE || last) begin
         window_fill = 0;
         hit         = 1'b0;
         byte_count  = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin : line_watch
      line_result_type got;
      line_result_type want;
      line_result_type fresh;
      if (reset) begin
         pattern_len = PATTERN_LEN_BITS'(1);
         foreach (pattern[i]) pattern[i] = '0;
         foreach (history[i]) history[i] = '0;
         window_fill = 0;
         hit         = 1'b0;
         byte_count  = 0;
         expected_lines.delete();
      end else begin
         // responses belong to earlier requests, so compare before this edge's request
         if (rsp_if.valid && rsp_if.ready) begin
            got.matched = rsp_if.line_matched;
            got.length  = rsp_if.line_length;
            if (expected_lines.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected line result: expected none, got matched %0b length %0d",
                        $time, got.matched, got.length);
            end else begin
               want = expected_lines.pop_front();
               if (got.matched !== want.matched) begin
                  mismatches++;
                  $display("%0t: line_matched mismatch: expected %0b, got %0b",
                           $time, want.matched, got.matched);
               end
               if (got.length !== want.length) begin
                  mismatches++;
                  $display("%0t: line_length mismatch: expected %0d, got %0d",
                           $time, want.length, got.length);
               end
            end
         end
         if (csr_if.valid && csr_if.ready) apply_register(csr_if.index, csr_if.data);
         if (req_if.valid && req_if.ready)
            if (scan_byte(req_if.text_byte, req_if.end_of_input, fresh))
               expected_lines.push_back(fresh);
      end
      lines_waiting <= expected_lines.size();
   end

endmodule : flm_line_checker

@@ test/testbench.sv @@
// top of the fixed-string line matcher test: clock, reset, text and register stimulus
// with random pacing on both channels, verdict from the line checker's mismatch count
// depends on flm_pkg, flm_channels, fixed_string_line_matcher and flm_line_checker
`timescale 1ns / 1ps

module testbench;
   import flm_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_FIRST = 3'd5;
   localparam int RANDOM_ITEMS = 2000;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef enum int {PLANT_NONE, PLANT_WHOLE, PLANT_PREFIX} plant_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bit            calm;
   bit            long_hold;
   int unsigned   sent_count;
   int            cfg_span;
   text_byte_type cfg_pattern [PATTERN_MAX];
   int unsigned   mismatches;
   int unsigned   lines_waiting;

   flm_req_if req_if ();
   flm_rsp_if rsp_if ();
   flm_csr_if csr_if ();

   fixed_string_line_matcher dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   flm_line_checker line_check (
      .clock         (clock),
      .reset         (reset),
      .req_if        (req_if),
      .rsp_if        (rsp_if),
      .csr_if        (csr_if),
      .mismatches    (mismatches),
      .lines_waiting (lines_waiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic text_byte_type pick_text_byte();
      case ($urandom_range(0, 3))
         0, 1: return (cfg_span > 0) ? cfg_pattern[$urandom_range(0, cfg_span - 1)] : 8'h61;
         2: return text_byte_type'($urandom_range(0, 255));
         default: return 8'h61 + text_byte_type'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic void randomize_pattern(input bit narrow);
      foreach (cfg_pattern[i])
         cfg_pattern[i] = narrow ? 8'h61 + text_byte_type'($urandom_range(0, 3))
                                 : text_byte_type'($urandom_range(0, 255));
   endfunction

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                 input logic [CSR_DATA_BITS-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // unused index first with junk data, then length and all four pattern words
   task automatic load_pattern(input logic [PATTERN_LEN_BITS-1:0] len_code);
      logic [CSR_DATA_BITS-1:0] word;
      cfg_span = (len_code > PATTERN_MAX) ? PATTERN_MAX : len_code;
      write_register(CSR_UNUSED_FIRST + CSR_INDEX_BITS'($urandom_range(0, 2)),
                     {$urandom, $urandom});
      word = {$urandom, $urandom};
      word[PATTERN_LEN_BITS-1:0] = len_code;
      write_register(CSR_PATTERN_LENGTH, word);
      for (int w = 0; w < PATTERN_REG_BYTES / WORD_BYTES; w++) begin
         for (int b = 0; b < WORD_BYTES; b++)
            word[8*b +: 8] = (w*WORD_BYTES + b < PATTERN_MAX) ? cfg_pattern[w*WORD_BYTES + b]
                                                              : text_byte_type'($urandom);
         write_register(CSR_INDEX_BITS'(CSR_PATTERN_WORD_0 + w), word);
      end
      csr_if.valid <= 1'b0;
   endtask

   task automatic send_text(input text_byte_type b, input logic last);
      int gap;
      if (!calm && $urandom_range(0, 9) == 0) begin
         gap = $urandom_range(1, 14);
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.text_byte    <= b;
      req_if.end_of_input <= last;
      do @(posedge clock); while (!req_if.ready);
      sent_count++;
   endtask

   task automatic send_line(input int body_len, input plant_type plant, input bit close_by_end);
      text_byte_type line_q [$];
      int            at;
      int            count;
      for (int i = 0; i < body_len; i++) line_q.push_back(pick_text_byte());
      count = (plant == PLANT_WHOLE) ? cfg_span : (plant == PLANT_PREFIX) ? cfg_span - 1 : 0;
      if (count < 0) count = 0;
      at = $urandom_range(0, line_q.size());
      for (int k = 0; k < count; k++) line_q.insert(at + k, cfg_pattern[k]);
      line_q.push_back(close_by_end ? pick_text_byte() : NEWLINE);
      foreach (line_q[i]) send_text(line_q[i], close_by_end && (i == line_q.size() - 1));
   endtask

   task automatic wait_lines_settled();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (lines_waiting != 0);
      repeat (3) @(posedge clock);
   endtask

   initial begin : response_pacing
      int span;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            span = $urandom_range(1, 14);
            rsp_if.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int                          directed_end;
      int                          phase_lines;
      logic [PATTERN_LEN_BITS-1:0] len_code;
      bit                          stall_done;
      req_if.valid        <= 1'b0;
      req_if.text_byte    <= '0;
      req_if.end_of_input <= 1'b0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= '0;
      csr_if.data         <= '0;
      calm       = 1'b0;
      long_hold  = 1'b0;
      stall_done = 1'b0;
      sent_count = 0;
      cfg_span   = 1;
      foreach (cfg_pattern[i]) cfg_pattern[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset pattern is one zero byte
      send_text(8'h00, 1'b0);
      send_text(NEWLINE, 1'b0);
      send_text(8'h61, 1'b0);
      send_text(8'h62, 1'b1);
      wait_lines_settled();

      // empty pattern matches every line
      load_pattern('0);
      send_text(NEWLINE, 1'b0);
      send_text(8'h7a, 1'b1);
      wait_lines_settled();

      // pattern ending in a newline, and a match split over two lines
      cfg_pattern[0] = 8'h61;
      cfg_pattern[1] = 8'h62;
      cfg_pattern[2] = NEWLINE;
      load_pattern(PATTERN_LEN_BITS'(3));
      send_text(8'h78, 1'b0);
      send_text(8'h61, 1'b0);
      send_text(8'h62, 1'b0);
      send_text(NEWLINE, 1'b0);
      send_text(8'h61, 1'b0);
      send_text(NEWLINE, 1'b0);
      send_text(8'h62, 1'b0);
      send_text(NEWLINE, 1'b1);
      wait_lines_settled();

      // extreme byte values
      cfg_pattern[0] = 8'hff;
      cfg_pattern[1] = 8'h00;
      load_pattern(PATTERN_LEN_BITS'(2));
      send_text(8'hff, 1'b0);
      send_text(8'h00, 1'b1);
      send_text(8'h00, 1'b0);
      send_text(8'hff, 1'b0);
      send_text(NEWLINE, 1'b0);
      wait_lines_settled();

      // full-width pattern, then a length code above the maximum
      randomize_pattern(1'b0);
      load_pattern(PATTERN_LEN_BITS'(PATTERN_MAX));
      send_line(0, PLANT_WHOLE, 1'b0);
      send_line(3, PLANT_PREFIX, 1'b1);
      wait_lines_settled();
      load_pattern('1);
      send_line(2, PLANT_WHOLE, 1'b0);
      wait_lines_settled();

      // line length saturation
      calm = 1'b1;
      cfg_pattern[0] = 8'h7a;
      cfg_pattern[1] = 8'h7a;
      load_pattern(PATTERN_LEN_BITS'(2));
      repeat (LINE_LENGTH_BITS == 16 ? 65540 : (1 << LINE_LENGTH_BITS) + 4)
         send_text(8'h61, 1'b0);
      send_text(8'h7a, 1'b0);
      send_text(8'h7a, 1'b0);
      send_text(NEWLINE, 1'b0);
      wait_lines_settled();

      directed_end = sent_count;
      while (sent_count - directed_end < RANDOM_ITEMS) begin
         wait_lines_settled();
         calm = (sent_count - directed_end > RANDOM_ITEMS * 85 / 100) || ($urandom_range(0, 3) == 0);
         randomize_pattern($urandom_range(0, 4) != 0);
         case ($urandom_range(0, 9))
            0: len_code = '0;
            1: len_code = PATTERN_LEN_BITS'(PATTERN_MAX);
            2: len_code = PATTERN_LEN_BITS'($urandom_range(PATTERN_MAX + 1, 63));
            3: len_code = PATTERN_LEN_BITS'(1);
            default: len_code = PATTERN_LEN_BITS'($urandom_range(2, 6));
         endcase
         load_pattern(len_code);
         if (!stall_done && sent_count - directed_end > RANDOM_ITEMS * 2 / 5) begin
            long_hold  = 1'b1;
            stall_done = 1'b1;
         end
         phase_lines = $urandom_range(10, 30);
         repeat (phase_lines)
            send_line(($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12),
                      plant_type'($urandom_range(0, 2)), $urandom_range(0, 7) == 0);
      end
      wait_lines_settled();

      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule : testbench

@@ filelist.f @@
rtl/flm_pkg.sv
rtl/flm_channels.sv
rtl/flm_csr_regs.sv
rtl/flm_cell.sv
rtl/fixed_string_line_matcher.sv
test/flm_line_checker.sv
test/testbench.sv
